// ===== rtl/core/rsvm_pkg.sv =====
// Package for the register-stack VM core: widths, opcodes, request and status codes.
// No dependencies.
`timescale 1ns / 1ps
package rsvm_pkg;
    localparam int MEM_WORDS_DEF = 512;
    localparam int REG_COUNT_DEF = 32;
    localparam int WORD_W = 32;
    localparam int REG_AW = 5;
    localparam int CFG_W = 10;
    localparam int LOAD_AW = 9;

    localparam logic [REG_AW-1:0] R_IP = 5'd0;
    localparam logic [REG_AW-1:0] R_RP = 5'd29;
    localparam logic [REG_AW-1:0] R_FP = 5'd30;
    localparam logic [REG_AW-1:0] R_SP = 5'd31;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0, REQ_RESTART = 2'd1, REQ_STEP = 2'd2, REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0, ST_HALT = 2'd1, ST_ERROR = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ERR_NONE = 3'd0, ERR_FETCH = 3'd1, ERR_REG = 3'd2, ERR_OPCODE = 3'd3,
        ERR_DATA = 3'd4, ERR_STACK = 3'd5, ERR_DIV0 = 3'd6
    } err_t;

    localparam logic [WORD_W-1:0] OP_MOVI = 32'd1;
    localparam logic [WORD_W-1:0] OP_MOV  = 32'd2;
    localparam logic [WORD_W-1:0] OP_ADD  = 32'd3;
    localparam logic [WORD_W-1:0] OP_SUB  = 32'd4;
    localparam logic [WORD_W-1:0] OP_MUL  = 32'd5;
    localparam logic [WORD_W-1:0] OP_IDIV = 32'd6;
    localparam logic [WORD_W-1:0] OP_JMP  = 32'd7;
    localparam logic [WORD_W-1:0] OP_JNZ  = 32'd8;
    localparam logic [WORD_W-1:0] OP_OUT  = 32'd9;
    localparam logic [WORD_W-1:0] OP_HALT = 32'd10;
    localparam logic [WORD_W-1:0] OP_LD   = 32'd11;
    localparam logic [WORD_W-1:0] OP_ST   = 32'd12;
    localparam logic [WORD_W-1:0] OP_JAL  = 32'd13;
    localparam logic [WORD_W-1:0] OP_RET  = 32'd14;
    localparam logic [WORD_W-1:0] OP_PUSH = 32'd15;
    localparam logic [WORD_W-1:0] OP_POP  = 32'd16;
    localparam logic [WORD_W-1:0] OP_LDLO = 32'd17;
    localparam logic [WORD_W-1:0] OP_STLO = 32'd18;

    typedef enum logic [4:0] {
        S_IDLE, S_FETCH_OP, S_OP_WAIT, S_FETCH_A, S_A_WAIT, S_FETCH_B, S_B_WAIT,
        S_REG_A, S_REG_A_WAIT, S_REG_B, S_REG_B_WAIT, S_EXEC, S_DIV, S_MEM_WAIT,
        S_WRITE, S_RESP
    } state_t;
endpackage

// ===== rtl/core/rsvm_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rsvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/rsvm_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rsvm_pkg.
`timescale 1ns / 1ps
module rsvm_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rsvm_pkg::WORD_W-1:0] dividend,
    input  logic [rsvm_pkg::WORD_W-1:0] divisor,
    output logic                      done,
    output logic [rsvm_pkg::WORD_W-1:0] quotient
);
    import rsvm_pkg::*;

    logic [WORD_W-1:0] rem_reg, quo_reg, den_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg, neg_reg, done_reg;
    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] rem_shift;

    assign rem_shift = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
    assign trial = {1'b0, rem_shift} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= 6'(WORD_W);
                rem_reg  <= '0;
                quo_reg  <= dividend[WORD_W-1] ? -dividend : dividend;
                den_reg  <= divisor[WORD_W-1] ? -divisor : divisor;
                neg_reg  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            end else if (busy_reg) begin
                if (trial[WORD_W]) begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
                end else begin
                    rem_reg <= trial[WORD_W-1:0];
                    quo_reg <= {quo_reg[WORD_W-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 6'd1;
                done_reg <= (cnt_reg == 6'd1);
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign quotient = neg_reg ? -quo_reg : quo_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) busy_reg |-> !start)
        else $error("divider restarted while busy");
endmodule

// ===== rtl/core/register_stack_vm_core.sv =====
// Top level of the register-stack VM core: sequencer, register file and memory.
// Depends on rsvm_pkg, rsvm_ram, rsvm_div.
//
// channel | dir | beat
// s_      | in  | tuser = req_type; tdata = load_addr[8:0], load_data[40:9]
// m_      | out | tuser = status[1:0], error_kind[4:2]; tdata = out_valid, out_value, ip_now
// cfg_    | in  | cfg_data = stack_base
//
// A step's length is set by the single memory port (up to three word fetches plus one
// data access) and the single register file port (three reads, IP and then the two
// operands, then SP, destination and IP written in turn); IDIV also waits on the divider.
// Reset clears the register file by a sweep during which s_tready stays low. One item is
// in work at a time; the result register holds while m_tready is low, and the next item
// waits before its response until that result is taken.
`timescale 1ns / 1ps
module register_stack_vm_core #(
    parameter int MEM_WORDS = rsvm_pkg::MEM_WORDS_DEF,
    parameter int REG_COUNT = rsvm_pkg::REG_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rsvm_pkg::CFG_W-1:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // req_type
    input  logic [47:0] s_tdata,   // load_addr[8:0], load_data[40:9], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [4:0]  m_tuser,   // status[1:0], error_kind[4:2]
    output logic [71:0] m_tdata    // out_valid[0], out_value[32:1], ip_now[64:33], zero
);
    import rsvm_pkg::*;

    localparam int MAW = $clog2(MEM_WORDS);
    localparam int RAW = $clog2(REG_COUNT);
    localparam logic [2:0] PEND_HALT = 3'd7;

    state_t state_reg, state_next;
    logic [CFG_W-1:0]  base_reg;
    logic              clr_reg;
    logic [RAW:0]      clr_cnt_reg;
    logic [1:0]        req_reg;
    logic [LOAD_AW-1:0] laddr_reg;
    logic [WORD_W-1:0] ldata_reg;
    logic [WORD_W-1:0] ip_reg, op_reg, a_reg, b_reg, va_reg, vb_reg, ipn_reg;
    logic [WORD_W-1:0] fp_reg, sp_reg, rp_reg, mrd_reg;
    logic [1:0]        rst_phase_reg;

    logic              mem_we;
    logic [MAW-1:0]    mem_addr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;
    logic              rf_we;
    logic [RAW-1:0]    rf_addr;
    logic [WORD_W-1:0] rf_wdata, rf_rdata;

    logic              div_start, div_done;
    logic [WORD_W-1:0] div_q;

    logic              m_valid_reg;
    logic [1:0]        st_reg;
    logic [2:0]        ek_reg;
    logic              ov_reg;
    logic [WORD_W-1:0] oval_reg, ipo_reg;

    // decoded classes
    logic cls_imm, cls_two, cls_one, has_b, need_va, need_vb;
    always_comb begin
        cls_imm = (op_reg == OP_MOVI) || (op_reg == OP_LDLO) || (op_reg == OP_STLO);
        cls_two = (op_reg == OP_MOV) || (op_reg == OP_ADD) || (op_reg == OP_SUB) ||
                  (op_reg == OP_MUL) || (op_reg == OP_IDIV) || (op_reg == OP_JNZ) ||
                  (op_reg == OP_LD) || (op_reg == OP_ST);
        cls_one = (op_reg == OP_JMP) || (op_reg == OP_OUT) || (op_reg == OP_JAL) ||
                  (op_reg == OP_PUSH) || (op_reg == OP_POP);
        has_b = cls_imm || cls_two;
        need_va = cls_two || (cls_one && op_reg != OP_POP);
        need_vb = cls_two || (op_reg == OP_STLO);
    end

    function automatic logic addr_ok(input logic [WORD_W-1:0] v);
        return v < WORD_W'(MEM_WORDS);
    endfunction

    logic [RAW-1:0]    rf_raddr_reg;
    logic [WORD_W-1:0] rd0_val;
    assign rd0_val = (rf_raddr_reg == RAW'(R_IP)) ? ip_reg : rf_rdata;

    // exec results
    logic [WORD_W-1:0] lo_addr, nsp, mul_res;
    assign lo_addr = fp_reg + a_reg;
    assign nsp = sp_reg - 32'd1;
    assign mul_res = vb_reg * va_reg;

    logic [2:0]        ex_err;
    logic              ex_halt, ex_mem_rd, ex_mem_wr, ex_wb, ex_out;
    logic [RAW-1:0]    ex_wb_reg;
    logic [WORD_W-1:0] ex_wb_val, ex_ip, ex_maddr, ex_mwdata;
    logic              ex_sp_wr;
    logic [WORD_W-1:0] ex_sp_val;
    always_comb begin
        ex_err = ERR_NONE; ex_halt = 1'b0; ex_mem_rd = 1'b0; ex_mem_wr = 1'b0;
        ex_wb = 1'b0; ex_wb_reg = b_reg[RAW-1:0]; ex_wb_val = '0; ex_ip = ipn_reg;
        ex_maddr = '0; ex_mwdata = vb_reg; ex_out = 1'b0; ex_sp_wr = 1'b0;
        ex_sp_val = '0;
        case (op_reg)
            OP_MOVI: begin ex_wb = 1'b1; ex_wb_val = a_reg; end
            OP_LDLO: begin
                if (!addr_ok(lo_addr)) ex_err = ERR_DATA;
                else begin ex_mem_rd = 1'b1; ex_maddr = lo_addr; end
            end
            OP_STLO: begin
                if (!addr_ok(lo_addr)) ex_err = ERR_DATA;
                else begin ex_mem_wr = 1'b1; ex_maddr = lo_addr; end
            end
            OP_MOV: begin ex_wb = 1'b1; ex_wb_val = va_reg; end
            OP_ADD: begin ex_wb = 1'b1; ex_wb_val = vb_reg + va_reg; end
            OP_SUB: begin ex_wb = 1'b1; ex_wb_val = vb_reg - va_reg; end
            OP_MUL: begin ex_wb = 1'b1; ex_wb_val = mul_res; end
            OP_IDIV: begin
                if (va_reg == '0) ex_err = ERR_DIV0;
                else begin ex_wb = 1'b1; ex_wb_val = div_q; end
            end
            OP_JNZ: begin if (va_reg != '0) ex_ip = vb_reg; end
            OP_LD: begin
                if (!addr_ok(va_reg)) ex_err = ERR_DATA;
                else begin ex_mem_rd = 1'b1; ex_maddr = va_reg; end
            end
            OP_ST: begin
                if (!addr_ok(va_reg)) ex_err = ERR_DATA;
                else begin ex_mem_wr = 1'b1; ex_maddr = va_reg; end
            end
            OP_JMP: ex_ip = va_reg;
            OP_OUT: ex_out = 1'b1;
            OP_JAL: begin
                // RP is written before the target is read
                ex_wb = 1'b1; ex_wb_reg = RAW'(R_RP); ex_wb_val = ipn_reg;
                ex_ip = (a_reg[RAW-1:0] == RAW'(R_RP)) ? ipn_reg : va_reg;
            end
            OP_PUSH: begin
                if (!addr_ok(sp_reg)) ex_err = ERR_STACK;
                else begin
                    ex_mem_wr = 1'b1; ex_maddr = sp_reg; ex_mwdata = va_reg;
                    ex_sp_wr = 1'b1; ex_sp_val = sp_reg + 32'd1;
                end
            end
            OP_POP: begin
                if (!addr_ok(nsp)) ex_err = ERR_STACK;
                else begin
                    ex_mem_rd = 1'b1; ex_maddr = nsp; ex_wb_reg = a_reg[RAW-1:0];
                    ex_sp_wr = 1'b1; ex_sp_val = nsp;
                end
            end
            OP_HALT: ex_halt = 1'b1;
            OP_RET: ex_ip = rp_reg;
            default: ex_err = ERR_OPCODE;
        endcase
    end

    // pending write-back after exec
    logic              wb_pend_reg, sp_pend_reg, out_pend_reg, rdwb_reg;
    logic [RAW-1:0]    wb_r_reg;
    logic [WORD_W-1:0] wb_v_reg, sp_v_reg, ipw_reg;
    logic [1:0]        wb_step_reg;

    logic s_fire, m_fire;
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_valid_reg && m_tready;
    assign s_tready = (state_reg == S_IDLE) && !clr_reg;
    assign cfg_ready = 1'b1;

    logic             resp_go;
    logic [1:0]       resp_st;
    logic [2:0]       resp_ek;
    logic             resp_ov;
    logic [WORD_W-1:0] resp_oval, resp_ip;

    logic [WORD_W-1:0] fetch_addr;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_fire) begin
                if (s_tuser == REQ_STEP) state_next = S_REG_A;
                else state_next = S_RESP;
            end
            S_REG_A: state_next = S_REG_A_WAIT;
            S_REG_A_WAIT: state_next = S_FETCH_OP;
            S_FETCH_OP: state_next = addr_ok(ip_reg) ? S_OP_WAIT : S_RESP;
            S_OP_WAIT: state_next = S_FETCH_A;
            S_FETCH_A: begin
                if (op_reg == OP_HALT || op_reg == OP_RET) state_next = S_EXEC;
                else if (!(cls_imm || cls_two || cls_one)) state_next = S_EXEC;
                else state_next = addr_ok(ipn_reg) ? S_A_WAIT : S_RESP;
            end
            S_A_WAIT: state_next = S_FETCH_B;
            S_FETCH_B: begin
                if (!cls_imm && a_reg >= WORD_W'(REG_COUNT)) state_next = S_RESP;
                else if (!has_b) state_next = S_REG_B;
                else state_next = addr_ok(ipn_reg) ? S_B_WAIT : S_RESP;
            end
            S_B_WAIT: state_next = S_REG_B;
            S_REG_B: begin
                if (has_b && b_reg >= WORD_W'(REG_COUNT)) state_next = S_RESP;
                else state_next = S_REG_B_WAIT;
            end
            S_REG_B_WAIT: state_next = (op_reg == OP_IDIV && va_reg != '0) ? S_DIV : S_EXEC;
            S_DIV: if (div_done) state_next = S_EXEC;
            S_EXEC: begin
                if (ex_err != ERR_NONE || ex_halt) state_next = S_RESP;
                else if (ex_mem_rd) state_next = S_MEM_WAIT;
                else state_next = S_WRITE;
            end
            S_MEM_WAIT: state_next = S_WRITE;
            S_WRITE: if (wb_step_reg == 2'd2) state_next = S_RESP;
            S_RESP: if ((req_reg != REQ_RESTART || rst_phase_reg[1]) &&
                        (!m_valid_reg || m_tready)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // memory and register-file port control
    always_comb begin
        mem_we = 1'b0; mem_addr = '0; mem_wdata = ex_mwdata;
        rf_we = 1'b0; rf_addr = '0; rf_wdata = '0;
        fetch_addr = ipn_reg;
        if (clr_reg) begin
            rf_we = 1'b1; rf_addr = clr_cnt_reg[RAW-1:0]; rf_wdata = '0;
        end
        case (state_reg)
            S_IDLE: if (s_fire && s_tuser == REQ_LOAD &&
                        32'(s_tdata[LOAD_AW-1:0]) < WORD_W'(MEM_WORDS)) begin
                mem_we = 1'b1; mem_addr = MAW'(s_tdata[LOAD_AW-1:0]);
                mem_wdata = s_tdata[LOAD_AW +: WORD_W];
            end
            S_REG_A: rf_addr = RAW'(R_IP);
            S_FETCH_OP: mem_addr = ip_reg[MAW-1:0];
            S_FETCH_A: mem_addr = fetch_addr[MAW-1:0];
            S_FETCH_B: begin
                mem_addr = fetch_addr[MAW-1:0];
                rf_addr = a_reg[RAW-1:0];
            end
            S_REG_B: rf_addr = b_reg[RAW-1:0];
            S_EXEC: if (ex_err == ERR_NONE && !ex_halt) begin
                mem_addr = ex_maddr[MAW-1:0];
                mem_we = ex_mem_wr;
            end
            S_WRITE: begin
                case (wb_step_reg)
                    2'd0: if (sp_pend_reg) begin
                        rf_we = 1'b1; rf_addr = RAW'(R_SP); rf_wdata = sp_v_reg;
                    end
                    2'd1: if (wb_pend_reg) begin
                        rf_we = 1'b1; rf_addr = wb_r_reg; rf_wdata = wb_v_reg;
                    end
                    default: begin
                        rf_we = 1'b1; rf_addr = RAW'(R_IP); rf_wdata = ipw_reg;
                    end
                endcase
            end
            S_RESP: if (req_reg == REQ_RESTART && rst_phase_reg != 2'd3) begin
                rf_we = 1'b1; rf_wdata = 32'(base_reg);
                case (rst_phase_reg)
                    2'd0: begin rf_addr = RAW'(R_IP); rf_wdata = '0; end
                    2'd1: rf_addr = RAW'(R_FP);
                    default: rf_addr = RAW'(R_SP);
                endcase
            end
            default: ;
        endcase
    end

    assign div_start = (state_reg == S_REG_B_WAIT) && (op_reg == OP_IDIV) && (va_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            base_reg <= '0;
            clr_reg <= 1'b1;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            rst_phase_reg <= '0;
            wb_step_reg <= '0;
        end else begin
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == (RAW+1)'(REG_COUNT - 1)) clr_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) base_reg <= cfg_data;
            if (resp_go) m_valid_reg <= 1'b1;
            else if (m_fire) m_valid_reg <= 1'b0;
            state_reg <= state_next;
            if (state_reg == S_RESP && req_reg == REQ_RESTART && rst_phase_reg != 2'd3)
                rst_phase_reg <= rst_phase_reg + 2'd1;
            else if (state_reg == S_IDLE) rst_phase_reg <= '0;
            if (state_reg == S_WRITE) wb_step_reg <= wb_step_reg + 2'd1;
            else wb_step_reg <= '0;
        end
    end

    // response construction
    logic [2:0] pend_err_reg;
    always_comb begin
        resp_go = 1'b0; resp_st = ST_DONE; resp_ek = ERR_NONE;
        resp_ov = 1'b0; resp_oval = '0; resp_ip = ip_reg;
        if (state_reg == S_RESP && state_next == S_IDLE) begin
            resp_go = 1'b1;
            if (pend_err_reg == PEND_HALT) resp_st = ST_HALT;
            else if (pend_err_reg != ERR_NONE) begin
                resp_st = ST_ERROR; resp_ek = pend_err_reg;
            end else if (out_pend_reg) begin
                resp_ov = 1'b1; resp_oval = va_reg;
            end
            if (req_reg == REQ_RESTART) resp_ip = '0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_reg <= '0;
        end else begin
            rf_raddr_reg <= rf_addr;
            if (state_reg == S_IDLE && s_fire) begin
                req_reg <= s_tuser;
                pend_err_reg <= ERR_NONE;
                out_pend_reg <= 1'b0;
                wb_pend_reg <= 1'b0;
                sp_pend_reg <= 1'b0;
                rdwb_reg <= 1'b0;
            end
            case (state_reg)
                S_REG_A_WAIT: begin ip_reg <= rf_rdata; ipn_reg <= rf_rdata; end
                S_FETCH_OP: if (!addr_ok(ip_reg)) pend_err_reg <= ERR_FETCH;
                    else ipn_reg <= ip_reg + 32'd1;
                S_OP_WAIT: op_reg <= mem_rdata;
                S_FETCH_A: begin
                    if (state_next == S_RESP) pend_err_reg <= ERR_FETCH;
                    else if (state_next == S_A_WAIT) ipn_reg <= ipn_reg + 32'd1;
                end
                S_A_WAIT: a_reg <= mem_rdata;
                S_FETCH_B: begin
                    if (!cls_imm && a_reg >= WORD_W'(REG_COUNT)) pend_err_reg <= ERR_REG;
                    else if (has_b && !addr_ok(ipn_reg)) pend_err_reg <= ERR_FETCH;
                    else if (has_b) ipn_reg <= ipn_reg + 32'd1;
                end
                S_B_WAIT: begin b_reg <= mem_rdata; va_reg <= rd0_val; end
                S_REG_B: begin
                    if (!has_b) va_reg <= rd0_val;
                    if (has_b && b_reg >= WORD_W'(REG_COUNT)) pend_err_reg <= ERR_REG;
                end
                S_REG_B_WAIT: if (need_vb) vb_reg <= rd0_val;
                S_EXEC: begin
                    if (ex_err != ERR_NONE) pend_err_reg <= ex_err;
                    else if (ex_halt) pend_err_reg <= PEND_HALT;
                    wb_pend_reg <= ex_wb || ex_mem_rd;
                    rdwb_reg <= ex_mem_rd;
                    wb_r_reg <= ex_wb_reg;
                    wb_v_reg <= ex_wb_val;
                    sp_pend_reg <= ex_sp_wr;
                    sp_v_reg <= ex_sp_val;
                    ipw_reg <= ex_ip;
                    out_pend_reg <= ex_out;
                end
                S_MEM_WAIT: if (rdwb_reg) wb_v_reg <= mem_rdata;
                S_WRITE: if (wb_step_reg == 2'd2) ip_reg <= ipw_reg;
                default: ;
            endcase
            if (resp_go) begin
                st_reg <= resp_st; ek_reg <= resp_ek; ov_reg <= resp_ov;
                oval_reg <= resp_oval; ipo_reg <= resp_ip;
            end
            if (state_reg == S_RESP && req_reg == REQ_RESTART) ip_reg <= '0;
        end
    end

    rsvm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_mem (
        .aclk(aclk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
    );

    // Register file: one port carries architectural reads and writes; FP, SP and
    // RP are mirrored in flops, updated on every write to those registers.
    rsvm_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf (
        .aclk(aclk), .we(rf_we), .addr(rf_addr), .wdata(rf_wdata), .rdata(rf_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fp_reg <= '0; sp_reg <= '0; rp_reg <= '0;
        end else if (rf_we) begin
            if (rf_addr == RAW'(R_FP)) fp_reg <= rf_wdata;
            if (rf_addr == RAW'(R_SP)) sp_reg <= rf_wdata;
            if (rf_addr == RAW'(R_RP)) rp_reg <= rf_wdata;
        end
    end

    rsvm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(rd0_val), .divisor(va_reg), .done(div_done), .quotient(div_q)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser = {ek_reg, st_reg};
    assign m_tdata = {7'd0, ipo_reg, oval_reg & {WORD_W{ov_reg}}, ov_reg};

    assert property (@(posedge aclk) disable iff (!aresetn) s_tready |-> state_reg == S_IDLE)
        else $error("input taken outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn) !(clr_reg && s_fire))
        else $error("item accepted during clear");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && state_reg == S_EXEC && ex_err != ERR_NONE))
        else $error("memory written on error");
    property p_resp_once;
        @(posedge aclk) disable iff (!aresetn) resp_go |=> m_valid_reg;
    endproperty
    assert property (p_resp_once) else $error("result lost");
endmodule
